// ===== design/tfm_pkg.sv =====
package tfm_pkg;

    localparam int QUAT_W  = 16;
    localparam int SCALE_W = 16;
    localparam int FIX_W   = 32;
    localparam int PROD_W  = 2 * QUAT_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int MUL_W   = ACC_W + SCALE_W;
    localparam int RND_SHIFT = 20;
    localparam int RES_W   = MUL_W - RND_SHIFT;
    localparam int AXIS_N  = 9;

    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [SCALE_W-1:0] scale_t;
    typedef logic signed [FIX_W-1:0]   fix_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [MUL_W-1:0]   mul_t;
    typedef logic signed [RES_W-1:0]   res_t;

    // 1.0 at the 2^28 scale of Q2.14 products
    localparam acc_t ONE_Q28  = acc_t'(64'sd1 <<< 28);
    localparam mul_t RND_HALF = mul_t'(64'sd1 <<< (RND_SHIFT - 1));

    typedef struct packed {
        prod_t xx;
        prod_t yy;
        prod_t zz;
        prod_t xy;
        prod_t xz;
        prod_t yz;
        prod_t wx;
        prod_t wy;
        prod_t wz;
    } prod_set_t;

    typedef struct packed {
        scale_t x;
        scale_t y;
        scale_t z;
    } scale_vec_t;

    typedef struct packed {
        fix_t x;
        fix_t y;
        fix_t z;
    } pos_vec_t;

endpackage

// ===== design/tfm_prod.sv =====
module tfm_prod (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tfm_pkg::quat_t      quat_w,
    input  tfm_pkg::quat_t      quat_x,
    input  tfm_pkg::quat_t      quat_y,
    input  tfm_pkg::quat_t      quat_z,
    input  tfm_pkg::scale_vec_t scale_in,
    input  tfm_pkg::pos_vec_t   pos_in,
    output logic                out_valid,
    input  logic                out_ready,
    output tfm_pkg::prod_set_t  prods,
    output tfm_pkg::scale_vec_t scale_out,
    output tfm_pkg::pos_vec_t   pos_out
);

    logic                valid_reg;
    tfm_pkg::prod_set_t  prods_reg;
    tfm_pkg::prod_set_t  prods_next;
    tfm_pkg::scale_vec_t scale_reg;
    tfm_pkg::pos_vec_t   pos_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        prods_next.xx = tfm_pkg::prod_t'(quat_x) * tfm_pkg::prod_t'(quat_x);
        prods_next.yy = tfm_pkg::prod_t'(quat_y) * tfm_pkg::prod_t'(quat_y);
        prods_next.zz = tfm_pkg::prod_t'(quat_z) * tfm_pkg::prod_t'(quat_z);
        prods_next.xy = tfm_pkg::prod_t'(quat_x) * tfm_pkg::prod_t'(quat_y);
        prods_next.xz = tfm_pkg::prod_t'(quat_x) * tfm_pkg::prod_t'(quat_z);
        prods_next.yz = tfm_pkg::prod_t'(quat_y) * tfm_pkg::prod_t'(quat_z);
        prods_next.wx = tfm_pkg::prod_t'(quat_w) * tfm_pkg::prod_t'(quat_x);
        prods_next.wy = tfm_pkg::prod_t'(quat_w) * tfm_pkg::prod_t'(quat_y);
        prods_next.wz = tfm_pkg::prod_t'(quat_w) * tfm_pkg::prod_t'(quat_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prods_reg <= prods_next;
            scale_reg <= scale_in;
            pos_reg   <= pos_in;
        end
    end

    assign out_valid = valid_reg;
    assign prods     = prods_reg;
    assign scale_out = scale_reg;
    assign pos_out   = pos_reg;

endmodule

// ===== design/tfm_axis.sv =====
module tfm_axis (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tfm_pkg::prod_set_t  prods,
    input  tfm_pkg::scale_vec_t scale_in,
    input  tfm_pkg::pos_vec_t   pos_in,
    output logic                out_valid,
    input  logic                out_ready,
    output tfm_pkg::acc_t       acc [tfm_pkg::AXIS_N],
    output tfm_pkg::scale_vec_t scale_out,
    output tfm_pkg::pos_vec_t   pos_out
);

    logic                valid_reg;
    tfm_pkg::acc_t       acc_reg  [tfm_pkg::AXIS_N];
    tfm_pkg::acc_t       acc_next [tfm_pkg::AXIS_N];
    tfm_pkg::scale_vec_t scale_reg;
    tfm_pkg::pos_vec_t   pos_reg;

    function automatic tfm_pkg::acc_t twice_sum(tfm_pkg::prod_t a, tfm_pkg::prod_t b);
        return (tfm_pkg::acc_t'(a) + tfm_pkg::acc_t'(b)) <<< 1;
    endfunction

    function automatic tfm_pkg::acc_t twice_diff(tfm_pkg::prod_t a, tfm_pkg::prod_t b);
        return (tfm_pkg::acc_t'(a) - tfm_pkg::acc_t'(b)) <<< 1;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    // rotated basis axes, column order, at scale 2^28
    always_comb begin
        acc_next[0] = tfm_pkg::ONE_Q28 - twice_sum(prods.yy, prods.zz);
        acc_next[1] = twice_sum(prods.xy, prods.wz);
        acc_next[2] = twice_diff(prods.xz, prods.wy);
        acc_next[3] = twice_diff(prods.xy, prods.wz);
        acc_next[4] = tfm_pkg::ONE_Q28 - twice_sum(prods.xx, prods.zz);
        acc_next[5] = twice_sum(prods.yz, prods.wx);
        acc_next[6] = twice_sum(prods.xz, prods.wy);
        acc_next[7] = twice_diff(prods.yz, prods.wx);
        acc_next[8] = tfm_pkg::ONE_Q28 - twice_sum(prods.xx, prods.yy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            acc_reg   <= acc_next;
            scale_reg <= scale_in;
            pos_reg   <= pos_in;
        end
    end

    assign out_valid = valid_reg;
    assign acc       = acc_reg;
    assign scale_out = scale_reg;
    assign pos_out   = pos_reg;

endmodule

// ===== design/tfm_scale.sv =====
module tfm_scale (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tfm_pkg::acc_t       acc [tfm_pkg::AXIS_N],
    input  tfm_pkg::scale_vec_t scale_in,
    input  tfm_pkg::pos_vec_t   pos_in,
    output logic                out_valid,
    input  logic                out_ready,
    output tfm_pkg::fix_t       col [tfm_pkg::AXIS_N],
    output tfm_pkg::pos_vec_t   pos_out
);

    // multiply stage
    logic              mul_valid_reg;
    logic              mul_ready;
    tfm_pkg::mul_t     mul_reg  [tfm_pkg::AXIS_N];
    tfm_pkg::mul_t     mul_next [tfm_pkg::AXIS_N];
    tfm_pkg::pos_vec_t mul_pos_reg;

    // round stage / output register
    logic              out_valid_reg;
    logic              rnd_ready;
    tfm_pkg::fix_t     col_reg  [tfm_pkg::AXIS_N];
    tfm_pkg::fix_t     col_next [tfm_pkg::AXIS_N];
    tfm_pkg::pos_vec_t pos_reg;

    tfm_pkg::mul_t     rnd_sum  [tfm_pkg::AXIS_N];
    tfm_pkg::res_t     rnd_res  [tfm_pkg::AXIS_N];
    tfm_pkg::scale_t   sc_sel   [tfm_pkg::AXIS_N];

    assign rnd_ready = !out_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || rnd_ready;
    assign in_ready  = mul_ready;

    always_comb begin
        for (int i = 0; i < tfm_pkg::AXIS_N; i++) begin
            if (i < 3) begin
                sc_sel[i] = scale_in.x;
            end else if (i < 6) begin
                sc_sel[i] = scale_in.y;
            end else begin
                sc_sel[i] = scale_in.z;
            end
            mul_next[i] = tfm_pkg::mul_t'(acc[i]) * tfm_pkg::mul_t'(sc_sel[i]);
        end
    end

    // add half then floor; the result magnitude stays below 2^28, so it
    // always fits Q16.16 and saturation never engages
    always_comb begin
        for (int i = 0; i < tfm_pkg::AXIS_N; i++) begin
            rnd_sum[i]  = mul_reg[i] + tfm_pkg::RND_HALF;
            rnd_res[i]  = rnd_sum[i][tfm_pkg::MUL_W-1:tfm_pkg::RND_SHIFT];
            col_next[i] = tfm_pkg::fix_t'(rnd_res[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (mul_ready) begin
                mul_valid_reg <= in_valid;
            end
            if (rnd_ready) begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && in_valid) begin
            mul_reg     <= mul_next;
            mul_pos_reg <= pos_in;
        end
        if (rnd_ready && mul_valid_reg) begin
            col_reg <= col_next;
            pos_reg <= mul_pos_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign col       = col_reg;
    assign pos_out   = pos_reg;

endmodule

// ===== design/transform_to_matrix_core.sv =====
// Transform (translation, quaternion, scale) to the top three rows of a 4x4 matrix.
// Pipeline stages, in order: products, axis sums, scale multiply, and rounding into the
// output register.
// Throughput: one item per cycle; each stage holds its item while the next is full.
// Reset: synchronous active-low aresetn clears all stage valid bits; data regs are not reset.
module transform_to_matrix_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z
    input  logic [207:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
    // col2_x, col2_y, col2_z, col3_x, col3_y, col3_z
    output logic [383:0] m_axis_tdata
);

    localparam int FW = tfm_pkg::FIX_W;

    tfm_pkg::quat_t      quat_w;
    tfm_pkg::quat_t      quat_x;
    tfm_pkg::quat_t      quat_y;
    tfm_pkg::quat_t      quat_z;
    tfm_pkg::scale_vec_t scale_in;
    tfm_pkg::pos_vec_t   pos_in;

    logic                p_valid;
    logic                p_ready;
    tfm_pkg::prod_set_t  p_prods;
    tfm_pkg::scale_vec_t p_scale;
    tfm_pkg::pos_vec_t   p_pos;

    logic                a_valid;
    logic                a_ready;
    tfm_pkg::acc_t       a_acc [tfm_pkg::AXIS_N];
    tfm_pkg::scale_vec_t a_scale;
    tfm_pkg::pos_vec_t   a_pos;

    tfm_pkg::fix_t       col [tfm_pkg::AXIS_N];
    tfm_pkg::pos_vec_t   o_pos;

    assign pos_in.x   = s_axis_tdata[31:0];
    assign pos_in.y   = s_axis_tdata[63:32];
    assign pos_in.z   = s_axis_tdata[95:64];
    assign quat_w     = s_axis_tdata[111:96];
    assign quat_x     = s_axis_tdata[127:112];
    assign quat_y     = s_axis_tdata[143:128];
    assign quat_z     = s_axis_tdata[159:144];
    assign scale_in.x = s_axis_tdata[175:160];
    assign scale_in.y = s_axis_tdata[191:176];
    assign scale_in.z = s_axis_tdata[207:192];

    tfm_prod u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .scale_in  (scale_in),
        .pos_in    (pos_in),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .prods     (p_prods),
        .scale_out (p_scale),
        .pos_out   (p_pos)
    );

    tfm_axis u_axis (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .prods     (p_prods),
        .scale_in  (p_scale),
        .pos_in    (p_pos),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .acc       (a_acc),
        .scale_out (a_scale),
        .pos_out   (a_pos)
    );

    tfm_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .acc       (a_acc),
        .scale_in  (a_scale),
        .pos_in    (a_pos),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .col       (col),
        .pos_out   (o_pos)
    );

    always_comb begin
        for (int i = 0; i < tfm_pkg::AXIS_N; i++) begin
            m_axis_tdata[i*FW +: FW] = col[i];
        end
        m_axis_tdata[9*FW +: FW]  = o_pos.x;
        m_axis_tdata[10*FW +: FW] = o_pos.y;
        m_axis_tdata[11*FW +: FW] = o_pos.z;
    end

endmodule
